// ===== rtl/fids_pkg.sv =====
`default_nettype none

package fids_pkg;

  // time and fixed-point formats
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned WIN_W    = 32;
  localparam int unsigned FREQ_W   = FRAC_BITS + 1;
  localparam int unsigned SP_W     = PERIOD_W + FREQ_W;
  localparam int unsigned NUM_W    = TIME_BITS + FRAC_BITS;
  localparam int unsigned CMP_W    = TIME_BITS + FRAC_BITS + 1;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned INT_W    = 40;
  localparam int unsigned MUL_W    = INT_W + GAIN_W + 1;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned BITS_W   = 4;

  localparam int unsigned FREQ_ONE = 1 << FRAC_BITS;
  localparam int unsigned FREQ_LO  = (FREQ_ONE * 4) / 5;
  localparam int unsigned FREQ_HI  = (FREQ_ONE * 6) / 5;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(2000);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(16384);

  localparam logic [COUNT_W-1:0] COUNT_TWO   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_THREE = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_FOUR  = COUNT_W'(4);
  localparam logic [BITS_W-1:0]  CELL_BITS   = 4'b1000;

  // register map, byte address 4*index
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_CELL_PERIOD = 2'd0,
    REG_INT_GAIN    = 2'd1,
    REG_WIN_START   = 2'd2,
    REG_WIN_END     = 2'd3
  } fids_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] cell_period;
    logic [GAIN_W-1:0]   integral_gain;
    logic [WIN_W-1:0]    window_start;
    logic [WIN_W-1:0]    window_end;
  } fids_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CMP3,
    ST_CMP4,
    ST_SUB,
    ST_DIFF,
    ST_DIV,
    ST_INTEG,
    ST_GAIN,
    ST_FREQ,
    ST_OUT
  } fids_state_e;

endpackage

`default_nettype wire

// ===== rtl/fids_regs.sv =====
`default_nettype none

module fids_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fids_pkg::APB_AW-1:0]   paddr,
  input  wire logic [fids_pkg::APB_DW-1:0]   pwdata,
  output logic      [fids_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output fids_pkg::fids_cfg_t                cfg_o
);
  import fids_pkg::*;

  fids_cfg_t cfg_q;
  fids_reg_e sel;
  logic      wr_en;

  assign sel    = fids_reg_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_period   <= PERIOD_RST;
      cfg_q.integral_gain <= GAIN_RST;
      cfg_q.window_start  <= '0;
      cfg_q.window_end    <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_CELL_PERIOD: cfg_q.cell_period   <= pwdata[PERIOD_W-1:0];
        REG_INT_GAIN:    cfg_q.integral_gain <= pwdata[GAIN_W-1:0];
        REG_WIN_START:   cfg_q.window_start  <= pwdata[WIN_W-1:0];
        REG_WIN_END:     cfg_q.window_end    <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CELL_PERIOD: prdata = APB_DW'(cfg_q.cell_period);
      REG_INT_GAIN:    prdata = APB_DW'(cfg_q.integral_gain);
      REG_WIN_START:   prdata = APB_DW'(cfg_q.window_start);
      REG_WIN_END:     prdata = APB_DW'(cfg_q.window_end);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/fids_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module fids_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [fids_pkg::NUM_W-1:0]    dividend_i,
  input  wire logic [fids_pkg::PERIOD_W-1:0] divisor_i,
  output logic                               done_o,
  output logic      [fids_pkg::NUM_W-1:0]    quotient_o
);
  import fids_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_W-1:0]    quo_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [PERIOD_W-1:0] dvs_q;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   trial_sub;
  logic                fits;

  assign trial     = {rem_q, quo_q[NUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/flux_interval_data_separator.sv =====
`default_nettype none

// channel     dir  handshake                     payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata[31:0] flux_time_ns
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata[23:0] count, bits, frequency
// apb         in   psel/penable/pwrite, pready=1 paddr[3:2] register, pwdata, prdata
//
// a kept timestamp with a previous one holds the sequencer after its transfer, so the
//   next input transfer waits until the result is loaded into the output register
// the sequencer runs the serial divider for the phase error (48 steps and a done
//   strobe), and its other steps work around one shared multiplier (scaled period,
//   then integral times gain)
// a skipped or priming timestamp leaves the sequencer idle, s_axis_tready stays high
// s_axis_tready is high only while the sequencer is idle
// the result sits in an output register; the next item is accepted while it waits,
//   and a further result holds the sequencer in its last step until that register frees
// async active-low reset: gain 0.25, period 2000, ratio 1.0, integral 0, no previous
module flux_interval_data_separator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] flux_time_ns
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,   // [2:0] cell_count, [6:3] cell_bits,
                                           // [23:7] frequency_ratio
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import fids_pkg::*;

  fids_cfg_t   cfg;
  fids_state_e state_q, state_d;

  // timing state
  logic                 prev_valid_q;
  logic [TIME_BITS-1:0] prev_time_q;
  logic [TIME_BITS-1:0] delta_q;
  logic [FREQ_W-1:0]    freq_q;
  logic signed [INT_W-1:0] integ_q;

  // working registers
  logic signed [MUL_W-1:0] prod_q;
  logic [COUNT_W-1:0]      count_q;
  logic [SP_W+1:0]         sub_q;
  logic                    neg_q;

  // output register
  logic                    out_valid_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic [FREQ_W-1:0]       out_freq_q;

  logic                    in_xfer;
  logic                    in_window;
  logic [TIME_BITS-1:0]    t_in;
  logic [PERIOD_W-1:0]     period_eff;
  logic [SP_W-1:0]         sp;
  logic [CMP_W-1:0]        delta_scaled;
  logic [SP_W+2:0]         sp_x5, sp_x7;
  logic [NUM_W-1:0]        num, sub_ext, mag;
  logic                    num_ge;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        quot;
  logic signed [ERR_W-1:0] err;
  logic signed [INT_W:0]   integ_sum;
  logic signed [INT_W-1:0] integ_sat;
  logic signed [INT_W-1:0] mul_a;
  logic signed [GAIN_W:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [INT_W-1:0] gain_q16;
  logic signed [INT_W:0]   freq_sum;
  logic [FREQ_W-1:0]       freq_clamped;
  logic                    out_load;

  fids_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // window check on the incoming timestamp
  assign t_in      = s_axis_tdata[TIME_BITS-1:0];
  assign in_window = (t_in >= cfg.window_start) &&
                     ((cfg.window_end == '0) || (t_in <= cfg.window_end));
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // zero period behaves as one
  assign period_eff = (cfg.cell_period == '0) ? PERIOD_W'(1) : cfg.cell_period;

  // shared multiplier: period*ratio first, integral*gain later
  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = $signed({{(INT_W-FREQ_W){1'b0}}, freq_q});
      mul_b = $signed({{(GAIN_W+1-PERIOD_W){1'b0}}, period_eff});
    end else begin
      mul_a = integ_q;
      mul_b = $signed({1'b0, cfg.integral_gain});
    end
  end
  assign mul_p = mul_a * mul_b;

  // count thresholds: interval*2^(F+1) against 5 and 7 scaled half periods
  assign sp           = prod_q[SP_W-1:0];
  assign delta_scaled = {delta_q, {(FRAC_BITS+1){1'b0}}};
  assign sp_x5        = {1'b0, sp, 2'b00} + {3'b000, sp};
  assign sp_x7        = {sp, 3'b000} - {3'b000, sp};

  // signed distance of the interval from count scaled periods
  assign num     = {delta_q, {FRAC_BITS{1'b0}}};
  assign sub_ext = NUM_W'(sub_q);
  assign num_ge  = num >= sub_ext;
  assign mag     = num_ge ? (num - sub_ext) : (sub_ext - num);
  assign div_start = (state_q == ST_DIFF);

  fids_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (period_eff),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // error in cells, saturated to 32 bits
  always_comb begin
    if (!neg_q) begin
      if (quot > NUM_W'({1'b0, {(ERR_W-1){1'b1}}})) begin
        err = $signed({1'b0, {(ERR_W-1){1'b1}}});
      end else begin
        err = $signed(quot[ERR_W-1:0]);
      end
    end else begin
      if (quot > NUM_W'({1'b1, {(ERR_W-1){1'b0}}})) begin
        err = $signed({1'b1, {(ERR_W-1){1'b0}}});
      end else begin
        err = -$signed(quot[ERR_W-1:0]);
      end
    end
  end

  // integral add with saturation to its own width
  assign integ_sum = {integ_q[INT_W-1], integ_q} + (INT_W+1)'(err);
  always_comb begin
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_sat = integ_sum[INT_W] ? $signed({1'b1, {(INT_W-1){1'b0}}})
                                   : $signed({1'b0, {(INT_W-1){1'b1}}});
    end else begin
      integ_sat = integ_sum[INT_W-1:0];
    end
  end

  // floor of the product by 2^16 is an arithmetic shift, then clamp the ratio
  assign gain_q16 = prod_q[INT_W+GAIN_W-1:GAIN_W];
  assign freq_sum = $signed((INT_W+1)'(FREQ_ONE)) + {gain_q16[INT_W-1], gain_q16};
  always_comb begin
    if (freq_sum < $signed((INT_W+1)'(FREQ_LO))) begin
      freq_clamped = FREQ_W'(FREQ_LO);
    end else if (freq_sum > $signed((INT_W+1)'(FREQ_HI))) begin
      freq_clamped = FREQ_W'(FREQ_HI);
    end else begin
      freq_clamped = freq_sum[FREQ_W-1:0];
    end
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_xfer && in_window && prev_valid_q) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_CMP3;
      ST_CMP3:  state_d = ST_CMP4;
      ST_CMP4:  state_d = ST_SUB;
      ST_SUB:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_INTEG;
      ST_INTEG: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_FREQ;
      ST_FREQ:  state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_time_q  <= '0;
      freq_q       <= FREQ_W'(FREQ_ONE);
      integ_q      <= '0;
    end else begin
      if (in_xfer && in_window) begin
        prev_valid_q <= 1'b1;
        prev_time_q  <= t_in;
      end
      if (state_q == ST_INTEG) integ_q <= integ_sat;
      if (state_q == ST_FREQ)  freq_q  <= freq_clamped;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) delta_q <= t_in - prev_time_q;
    if (state_q == ST_SCALE || state_q == ST_GAIN) prod_q <= mul_p;
    if (state_q == ST_CMP3) begin
      count_q <= (delta_scaled >= CMP_W'(sp_x5)) ? COUNT_THREE : COUNT_TWO;
    end
    if (state_q == ST_CMP4 && delta_scaled >= CMP_W'(sp_x7)) count_q <= COUNT_FOUR;
    if (state_q == ST_SUB) begin
      case (count_q)
        COUNT_THREE: sub_q <= {1'b0, sp, 1'b0} + {2'b00, sp};
        COUNT_FOUR:  sub_q <= {sp, 2'b00};
        default:     sub_q <= {1'b0, sp, 1'b0};
      endcase
    end
    if (state_q == ST_DIFF) neg_q <= !num_ge;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= count_q;
      out_freq_q  <= freq_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_freq_q, CELL_BITS, out_count_q};

endmodule

`default_nettype wire
